// ----- hdl/skm_pkg.sv -----
package skm_pkg;

	localparam int CODE_W = 10;
	localparam int MASK_W = 4;

	// Queue between classifier and sequencer
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Result kinds
	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_PASS   = 2'd1;
	localparam logic [1:0] KIND_SYNTH  = 2'd2;

	// Linux input keycodes of the modifiers
	localparam logic [CODE_W-1:0] CODE_CTRL_L  = 10'd29;
	localparam logic [CODE_W-1:0] CODE_CTRL_R  = 10'd97;
	localparam logic [CODE_W-1:0] CODE_ALT_L   = 10'd56;
	localparam logic [CODE_W-1:0] CODE_ALT_R   = 10'd100;
	localparam logic [CODE_W-1:0] CODE_SHIFT_L = 10'd42;
	localparam logic [CODE_W-1:0] CODE_SHIFT_R = 10'd54;
	localparam logic [CODE_W-1:0] CODE_SUPER_L = 10'd125;
	localparam logic [CODE_W-1:0] CODE_SUPER_R = 10'd126;

	// One classified item, as handed from front to back
	typedef struct packed {
		logic              expand;   // emit the synthesized chord sequence
		logic [1:0]        kind;     // kind of the single result when not expanding
		logic [CODE_W-1:0] code;
		logic              pressed;
		logic [MASK_W-1:0] held;
		logic [MASK_W-1:0] latched;
		logic [MASK_W-1:0] active;   // modifiers to wrap around the key
	} job_t;

endpackage

// ----- hdl/skm_front.sv -----
module skm_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic [skm_pkg::CODE_W-1:0] key_code,
	input  logic                       key_pressed,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic                       cfg_data,
	input  logic                       q_full,
	output logic                       q_push,
	output skm_pkg::job_t              q_job
);
	import skm_pkg::*;

	logic              enable_q;
	logic [MASK_W-1:0] held_q;
	logic [MASK_W-1:0] latched_q;

	logic              accept;
	logic [MASK_W-1:0] mod_bit;
	logic              is_mod;
	logic [MASK_W-1:0] active;
	logic [MASK_W-1:0] held_nx;
	logic [MASK_W-1:0] latched_nx;
	job_t              job;

	// Map a keycode to its modifier bit; zero for any other key
	function automatic logic [MASK_W-1:0] mod_of(input logic [CODE_W-1:0] c);
		logic [MASK_W-1:0] b;
		b = '0;
		if (c == CODE_CTRL_L || c == CODE_CTRL_R) b = 4'b0001;
		if (c == CODE_ALT_L || c == CODE_ALT_R) b = 4'b0010;
		if (c == CODE_SHIFT_L || c == CODE_SHIFT_R) b = 4'b0100;
		if (c == CODE_SUPER_L || c == CODE_SUPER_R) b = 4'b1000;
		return b;
	endfunction

	assign full      = q_full;
	assign cfg_ready = 1'b1;
	assign accept    = push && !q_full;
	assign q_push    = accept;
	assign q_job     = job;

	assign mod_bit = mod_of(key_code);
	assign is_mod  = |mod_bit;
	assign active  = held_q | latched_q;

	always_comb begin
		held_nx    = held_q;
		latched_nx = latched_q;
		job.expand  = 1'b0;
		job.kind    = KIND_PASS;
		job.code    = key_code;
		job.pressed = key_pressed;
		job.active  = active;
		if (!enable_q) begin
			job.kind = KIND_PASS;
		end else if (is_mod) begin
			if (key_pressed) begin
				priority if ((latched_q & mod_bit) != '0) begin
					latched_nx = latched_q & ~mod_bit;
				end else if ((held_q & mod_bit) != '0) begin
					held_nx    = held_q & ~mod_bit;
					latched_nx = latched_q | mod_bit;
				end else begin
					held_nx = held_q | mod_bit;
				end
			end
			job.kind    = KIND_STATUS;
			job.code    = '0;
			job.pressed = 1'b0;
		end else begin
			held_nx = '0;
			if (active == '0) begin
				job.kind = KIND_PASS;
			end else if (key_pressed) begin
				job.expand = 1'b1;
				job.kind   = KIND_SYNTH;
			end else begin
				job.kind    = KIND_STATUS;
				job.code    = '0;
				job.pressed = 1'b0;
			end
		end
		job.held    = held_nx;
		job.latched = latched_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b0;
			held_q    <= '0;
			latched_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) enable_q <= cfg_data;
			if (accept) begin
				held_q    <= held_nx;
				latched_q <= latched_nx;
			end
		end
	end

	// A plain key under sticky handling always drops the held modifiers
	a_plain_key_clears_held: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && enable_q && !is_mod) |=> (held_q == '0))
		else $error("held modifiers survived a plain key");

endmodule

// ----- hdl/skm_fifo.sv -----
module skm_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  skm_pkg::job_t wr_data,
	output logic          is_full,
	input  logic          rd_en,
	output skm_pkg::job_t rd_data,
	output logic          is_empty
);
	import skm_pkg::*;

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_wr;
	logic              do_rd;

	assign is_full  = (cnt_q == QCNT_W'(QDEPTH));
	assign is_empty = (cnt_q == '0);
	assign do_wr    = wr_en && !is_full;
	assign do_rd    = rd_en && !is_empty;
	assign rd_data  = mem_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= bump(wr_ptr_q);
			if (do_rd) rd_ptr_q <= bump(rd_ptr_q);
			if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
		end
	end

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("queue count out of range");

endmodule

// ----- hdl/skm_back.sv -----
module skm_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  skm_pkg::job_t              head,
	input  logic                       head_empty,
	output logic                       head_pop,
	output logic                       empty,
	input  logic                       pop,
	output logic [1:0]                 kind,
	output logic [skm_pkg::CODE_W-1:0] out_key_code,
	output logic                       out_pressed,
	output logic [skm_pkg::MASK_W-1:0] held_mask,
	output logic [skm_pkg::MASK_W-1:0] latched_mask,
	output logic                       last
);
	import skm_pkg::*;

	typedef enum logic [1:0] {
		PH_MODDN,
		PH_KEYDN,
		PH_KEYUP,
		PH_MODUP
	} phase_t;

	phase_t            phase_q;
	phase_t            nx_phase;
	logic [MASK_W-1:0] rem_q;
	logic              fresh_q;
	logic              valid_q;
	logic [1:0]        kind_q;
	logic [CODE_W-1:0] code_q;
	logic              pressed_q;
	logic [MASK_W-1:0] held_q;
	logic [MASK_W-1:0] latched_q;
	logic              last_q;

	logic              load;
	logic [MASK_W-1:0] eff_rem;
	logic [MASK_W-1:0] low;
	logic [MASK_W-1:0] low_rest;
	logic [MASK_W-1:0] high;
	logic [MASK_W-1:0] high_rest;
	logic [MASK_W-1:0] nx_rem;
	logic              nx_fresh;
	logic [1:0]        r_kind;
	logic [CODE_W-1:0] r_code;
	logic              r_pressed;
	logic              r_last;

	// Left-hand keycode of a one-hot modifier bit
	function automatic logic [CODE_W-1:0] left_code(input logic [MASK_W-1:0] b);
		logic [CODE_W-1:0] c;
		unique case (b)
			4'b0001: c = CODE_CTRL_L;
			4'b0010: c = CODE_ALT_L;
			4'b0100: c = CODE_SHIFT_L;
			4'b1000: c = CODE_SUPER_L;
			default: c = '0;
		endcase
		return c;
	endfunction

	assign load     = !head_empty && (!valid_q || pop);
	assign head_pop = load && r_last;

	// Presses walk the modifiers upward, releases walk them downward
	assign eff_rem  = fresh_q ? head.active : rem_q;
	assign low      = eff_rem & (~eff_rem + 1'b1);
	assign low_rest = eff_rem & ~low;

	always_comb begin
		priority if (rem_q[3]) high = 4'b1000;
		else if (rem_q[2]) high = 4'b0100;
		else if (rem_q[1]) high = 4'b0010;
		else high = 4'b0001;
	end
	assign high_rest = rem_q & ~high;

	always_comb begin
		r_kind    = head.kind;
		r_code    = head.code;
		r_pressed = head.pressed;
		r_last    = 1'b1;
		nx_phase  = PH_MODDN;
		nx_rem    = rem_q;
		nx_fresh  = 1'b1;
		if (head.expand) begin
			r_kind = KIND_SYNTH;
			unique case (phase_q)
				PH_MODDN: begin
					r_code    = left_code(low);
					r_pressed = 1'b1;
					r_last    = 1'b0;
					nx_rem    = low_rest;
					nx_fresh  = 1'b0;
					nx_phase  = (low_rest == '0) ? PH_KEYDN : PH_MODDN;
				end
				PH_KEYDN: begin
					r_pressed = 1'b1;
					r_last    = 1'b0;
					nx_rem    = head.active;
					nx_fresh  = 1'b0;
					nx_phase  = PH_KEYUP;
				end
				PH_KEYUP: begin
					r_pressed = 1'b0;
					r_last    = 1'b0;
					nx_fresh  = 1'b0;
					nx_phase  = PH_MODUP;
				end
				PH_MODUP: begin
					r_code    = left_code(high);
					r_pressed = 1'b0;
					r_last    = (high_rest == '0);
					nx_rem    = high_rest;
					if (high_rest != '0) begin
						nx_fresh = 1'b0;
						nx_phase = PH_MODUP;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MODDN;
			fresh_q <= 1'b1;
			rem_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				phase_q <= nx_phase;
				fresh_q <= nx_fresh;
				rem_q   <= nx_rem;
				valid_q <= 1'b1;
			end else if (pop) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Result payload holds until the slot is reloaded
	always_ff @(posedge clk) begin
		if (load) begin
			kind_q    <= r_kind;
			code_q    <= r_code;
			pressed_q <= r_pressed;
			held_q    <= head.held;
			latched_q <= head.latched;
			last_q    <= r_last;
		end
	end

	assign empty        = !valid_q;
	assign kind         = kind_q;
	assign out_key_code = code_q;
	assign out_pressed  = pressed_q;
	assign held_mask    = held_q;
	assign latched_mask = latched_q;
	assign last         = last_q;

	a_status_has_no_key: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && kind_q == KIND_STATUS) |-> (code_q == '0 && !pressed_q))
		else $error("status result carries a key");

	a_only_chords_continue: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !last_q) |-> (kind_q == KIND_SYNTH))
		else $error("non-final result outside a synthesized sequence");

endmodule

// ----- hdl/sticky_modifier_keys.sv -----
// Sticky modifier keys. Key events (keycode, press flag) go in through a queue-like
// push/full port and results come out through an empty/pop port, oldest first. With
// enable at 0 (its reset value) every event passes through unchanged as one result of
// kind 1. With enable at 1, a press of ctrl, alt, shift or super (either side) steps
// that modifier off -> held -> latched -> off and gives one status result (kind 0);
// modifier releases give a status result too. A plain key with no modifier active
// passes through. A plain key press with modifiers active is swallowed and replaced by
// synthesized events (kind 2): left-hand modifier presses in ctrl, alt, shift, super
// order, the key press, the key release, then the modifier releases in reverse; a plain
// key release with modifiers active gives one status result. Every plain key clears the
// held modifiers while latched ones stay. Each result carries the held and latched
// masks after its event, and last marks the final result of an event. Events enter at
// one per cycle while full is low, classified at once into a four-entry queue; a
// sequencer drains it at one result per cycle while the output is free or popped, so
// an event gives one result, or 2n+2 for a chord of n modifiers (at most 10). Write
// enable over the cfg port only while no event is in flight; cfg_ready is always high.
module sticky_modifier_keys (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic [skm_pkg::CODE_W-1:0] key_code,
	input  logic                       key_pressed,
	output logic                       empty,
	input  logic                       pop,
	output logic [1:0]                 kind,
	output logic [skm_pkg::CODE_W-1:0] out_key_code,
	output logic                       out_pressed,
	output logic [skm_pkg::MASK_W-1:0] held_mask,
	output logic [skm_pkg::MASK_W-1:0] latched_mask,
	output logic                       last,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic                       cfg_data
);
	import skm_pkg::*;

	// Classified events between front and back
	job_t q_in;
	job_t q_head;
	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;

	// Classify each event and advance the modifier state on acceptance
	skm_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.key_code    (key_code),
		.key_pressed (key_pressed),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_job       (q_in)
	);

	// Hold classified events so either side can stall on its own
	skm_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (q_push),
		.wr_data  (q_in),
		.is_full  (q_full),
		.rd_en    (q_pop),
		.rd_data  (q_head),
		.is_empty (q_empty)
	);

	// Expand each event into its results, one per cycle while the output register is free or popped
	skm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (q_head),
		.head_empty   (q_empty),
		.head_pop     (q_pop),
		.empty        (empty),
		.pop          (pop),
		.kind         (kind),
		.out_key_code (out_key_code),
		.out_pressed  (out_pressed),
		.held_mask    (held_mask),
		.latched_mask (latched_mask),
		.last         (last)
	);

endmodule
